// ===== hdl/lpcf_pkg.sv =====
// Shared constants and types of the label position conflict finder.
package lpcf_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int LABEL_W    = 12;
  localparam int PCOUNT_W   = 7;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = ((COORD_BITS > LABEL_W) ? COORD_BITS : LABEL_W) + 2;
  localparam int STATUS_W   = 2;
  localparam int MASK_W     = 16;
  localparam int OTHER_W    = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [STATUS_W-1:0] STAT_PAIR  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ALONE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

  localparam logic MODE_WRITE = 1'b0;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] q;
    logic             last;
  } tag_t;

endpackage

// ===== hdl/lpcf_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module lpcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lpcf_overlap.sv =====
// Shared overlap unit: registered coordinate differences, then the candidate compares.
module lpcf_overlap
  import lpcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [COORD_BITS-1:0] p_x,
  input  logic [COORD_BITS-1:0] p_y,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  input  logic [LABEL_W-1:0]    w,
  input  logic [LABEL_W-1:0]    h,
  input  tag_t                  tag_in,
  output tag_t                  tag_out,
  output logic [MASK_W-1:0]     mask
);

  logic signed [DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [DIFF_W-1:0] ws, w2s, hs, h2s;
  tag_t                     tag_r;
  logic                     xe, xp, xn, ye, yp, yn;

  assign dx_nxt = $signed({{(DIFF_W-COORD_BITS){1'b0}}, p_x})
                - $signed({{(DIFF_W-COORD_BITS){1'b0}}, q_x});
  assign dy_nxt = $signed({{(DIFF_W-COORD_BITS){1'b0}}, p_y})
                - $signed({{(DIFF_W-COORD_BITS){1'b0}}, q_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
  end

  assign ws  = $signed({{(DIFF_W-LABEL_W){1'b0}}, w});
  assign hs  = $signed({{(DIFF_W-LABEL_W){1'b0}}, h});
  assign w2s = ws <<< 1;
  assign h2s = hs <<< 1;

  // Same offset, p shifted left of q, p shifted right of q.
  assign xe = (dx_r <= ws)  && (dx_r >= -ws);
  assign xp = !dx_r[DIFF_W-1] && (dx_r <= w2s);
  assign xn = (dx_r[DIFF_W-1] || (dx_r == '0)) && (dx_r >= -w2s);
  assign ye = (dy_r <= hs)  && (dy_r >= -hs);
  assign yp = !dy_r[DIFF_W-1] && (dy_r <= h2s);
  assign yn = (dy_r[DIFF_W-1] || (dy_r == '0)) && (dy_r >= -h2s);

  always_comb begin
    logic [3:0] ib, jb;
    logic       fx, fy;
    mask = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        ib = 4'(i);
        jb = 4'(j);
        if (ib[1] == jb[1]) begin
          fx = xe;
        end else if (jb[1]) begin
          fx = xp;
        end else begin
          fx = xn;
        end
        if (ib[0] == jb[0]) begin
          fy = ye;
        end else if (jb[0]) begin
          fy = yp;
        end else begin
          fy = yn;
        end
        mask[i*4+j] = fx && fy;
      end
    end
  end

  assign tag_out = tag_r;

endmodule

// ===== hdl/label_position_conflict_finder_core.sv =====
// Top level of the label position conflict finder: sequencer, point memory and result register.
// A write item gives no result and leaves busy low; a query that is out of
// range or has no other point gives its single result in the cycle after acceptance.
// Any other query holds busy while it reads the queried point, reads each other point in
// turn and empties the compare pipeline; results come one per cycle and the
// receiver cannot stall. Synchronous reset sets width and height to 1 and the count to 0.
module label_position_conflict_finder_core
  import lpcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [IDX_W-1:0]      in_point_index,
  input  logic [COORD_BITS-1:0] in_coord_x,
  input  logic [COORD_BITS-1:0] in_coord_y,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LABEL_W-1:0]    cfg_data,
  output logic                  out_strobe,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OTHER_W-1:0]    out_other_point,
  output logic [MASK_W-1:0]     out_conflict_mask,
  output logic                  out_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CAPT,
    ST_WALK,
    ST_DRAIN
  } state_t;

  state_t                  state_r, state_nxt;
  logic [LABEL_W-1:0]      width_r, height_r;
  logic [PCOUNT_W-1:0]     pcount_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt, eff_cnt;
  logic [IDX_W-1:0]        p_r, p_nxt;
  logic [CNT_W-1:0]        q_r, q_nxt, q_plus, nq;
  logic [COORD_BITS-1:0]   px_r, px_nxt, py_r, py_nxt;
  tag_t                    tag1_r, tag1_nxt, tag2;
  logic                    out_strobe_r, out_strobe_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [OTHER_W-1:0]      out_other_r, out_other_nxt;
  logic [MASK_W-1:0]       out_mask_r, out_mask_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    accept, ram_we, issue, issue_last;
  logic [IDX_W-1:0]        raddr;
  logic [2*COORD_BITS-1:0] rdata;
  logic [MASK_W-1:0]       mask;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign ram_we  = accept && (in_mode == MODE_WRITE);
  assign eff_cnt = (pcount_r > PCOUNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(pcount_r);
  assign raddr   = (state_r == ST_LOAD) ? p_r : q_r[IDX_W-1:0];

  assign q_plus     = q_r + CNT_W'(1);
  assign nq         = (q_plus == CNT_W'(p_r)) ? q_r + CNT_W'(2) : q_plus;
  assign issue      = (state_r == ST_CAPT) || (state_r == ST_WALK);
  assign issue_last = (nq >= cnt_r);

  lpcf_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(MAX_POINTS)
  ) u_points (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_point_index),
    .wdata({in_coord_x, in_coord_y}),
    .raddr(raddr),
    .rdata(rdata)
  );

  lpcf_overlap u_overlap (
    .clk    (clk),
    .rst_n  (rst_n),
    .p_x    (px_r),
    .p_y    (py_r),
    .q_x    (rdata[2*COORD_BITS-1:COORD_BITS]),
    .q_y    (rdata[COORD_BITS-1:0]),
    .w      (width_r),
    .h      (height_r),
    .tag_in (tag1_r),
    .tag_out(tag2),
    .mask   (mask)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    p_nxt          = p_r;
    q_nxt          = q_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    tag1_nxt       = '0;
    out_strobe_nxt = 1'b0;
    out_status_nxt = STAT_PAIR;
    out_other_nxt  = '0;
    out_mask_nxt   = '0;
    out_last_nxt   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode != MODE_WRITE)) begin
          if (CNT_W'(in_point_index) >= eff_cnt) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = STAT_RANGE;
            out_last_nxt   = 1'b1;
          end else if (eff_cnt == CNT_W'(1)) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = STAT_ALONE;
            out_last_nxt   = 1'b1;
          end else begin
            cnt_nxt   = eff_cnt;
            p_nxt     = in_point_index;
            q_nxt     = (in_point_index == '0) ? CNT_W'(1) : '0;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = ST_CAPT;
      end
      ST_CAPT, ST_WALK: begin
        if (state_r == ST_CAPT) begin
          px_nxt = rdata[2*COORD_BITS-1:COORD_BITS];
          py_nxt = rdata[COORD_BITS-1:0];
        end
        state_nxt = issue_last ? ST_DRAIN : ST_WALK;
        q_nxt     = nq;
      end
      ST_DRAIN: begin
        if (tag2.valid && tag2.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (issue) begin
      tag1_nxt.valid = 1'b1;
      tag1_nxt.q     = q_r[IDX_W-1:0];
      tag1_nxt.last  = issue_last;
    end

    if (tag2.valid) begin
      out_strobe_nxt = 1'b1;
      out_status_nxt = STAT_PAIR;
      out_other_nxt  = OTHER_W'(tag2.q);
      out_mask_nxt   = mask;
      out_last_nxt   = tag2.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      width_r      <= LABEL_W'(1);
      height_r     <= LABEL_W'(1);
      pcount_r     <= '0;
      tag1_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tag1_r       <= tag1_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_data;
          REG_HEIGHT: height_r <= cfg_data;
          REG_COUNT:  pcount_r <= cfg_data[PCOUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
    cnt_r        <= cnt_nxt;
    p_r          <= p_nxt;
    q_r          <= q_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    out_status_r <= out_status_nxt;
    out_other_r  <= out_other_nxt;
    out_mask_r   <= out_mask_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_other_point   = out_other_r;
  assign out_conflict_mask = out_mask_r;
  assign out_last          = out_last_r;

endmodule
